// File: sv/cfpa_pkg.sv
// Shared types and constants for the complex fixed-point ALU.
package cfpa_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PART_W         = 32;
  localparam int S_TDATA_W      = 136;
  localparam int M_TDATA_W      = 72;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_ABS  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SAT = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // per-beat control that rides along the iteration pipe
  typedef struct packed {
    op_t  op;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
    logic sat;
  } ctrl_t;

endpackage

// File: sv/cfpa_iter.sv
// Pipelined restoring divider (two lanes) and integer square root, one bit per stage.
module cfpa_iter #(
  parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cfpa_pkg::ctrl_t                     in_ctrl,
  input  logic [DATA_WIDTH-1:0]               in_side_re,
  input  logic [DATA_WIDTH-1:0]               in_side_im,
  input  logic [3*DATA_WIDTH+FRAC_BITS+1:0]   in_num_re,
  input  logic [3*DATA_WIDTH+FRAC_BITS+1:0]   in_num_im,
  input  logic [2*DATA_WIDTH-1:0]             in_den,
  input  logic [2*DATA_WIDTH-1:0]             in_sq,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cfpa_pkg::ctrl_t                     out_ctrl,
  output logic [DATA_WIDTH-1:0]               out_side_re,
  output logic [DATA_WIDTH-1:0]               out_side_im,
  output logic [DATA_WIDTH:0]                 out_q_re,
  output logic [DATA_WIDTH:0]                 out_q_im,
  output logic [2*DATA_WIDTH-1:0]             out_root
);
  import cfpa_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int NS  = DW + 1;
  localparam int SW  = 2 * DW;
  localparam int RMW = 3 * DW + FRAC_BITS + 2;

  logic          v    [NS];
  logic [NS:0]   rdy;
  ctrl_t         ctl  [NS];
  logic [DW-1:0] sre  [NS];
  logic [DW-1:0] sim  [NS];
  logic [RMW-1:0] rre [NS];
  logic [RMW-1:0] rim [NS];
  logic [DW:0]   qre  [NS];
  logic [DW:0]   qim  [NS];
  logic [SW-1:0] den  [NS];
  logic [SW-1:0] sn   [NS];
  logic [SW-1:0] sr   [NS];

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar j = 0; j < NS; j++) begin : g_st
    localparam int  DBIT    = DW - j;
    localparam bit  SQ_STEP = (j < DW);
    localparam int  KK      = (j < DW) ? (DW - 1 - j) : 0;

    logic           pv;
    ctrl_t          pc;
    logic [DW-1:0]  pse, psi;
    logic [RMW-1:0] pre, pim;
    logic [DW:0]    pqr, pqi;
    logic [SW-1:0]  pden, pn, pr;

    logic [RMW-1:0] dsh, nre, nim;
    logic [DW:0]    nqr, nqi;
    logic [SW-1:0]  bsq, tsq, nn, nr;

    if (j == 0) begin : g_first
      assign pv   = in_valid;
      assign pc   = in_ctrl;
      assign pse  = in_side_re;
      assign psi  = in_side_im;
      assign pre  = in_num_re;
      assign pim  = in_num_im;
      assign pqr  = '0;
      assign pqi  = '0;
      assign pden = in_den;
      assign pn   = in_sq;
      assign pr   = '0;
    end else begin : g_next
      assign pv   = v[j-1];
      assign pc   = ctl[j-1];
      assign pse  = sre[j-1];
      assign psi  = sim[j-1];
      assign pre  = rre[j-1];
      assign pim  = rim[j-1];
      assign pqr  = qre[j-1];
      assign pqi  = qim[j-1];
      assign pden = den[j-1];
      assign pn   = sn[j-1];
      assign pr   = sr[j-1];
    end

    always_comb begin
      // quotient bit DBIT, both lanes share the divisor
      dsh = RMW'(pden) << DBIT;
      if (pre >= dsh) begin
        nre = pre - dsh;
        nqr = {pqr[DW-1:0], 1'b1};
      end else begin
        nre = pre;
        nqr = {pqr[DW-1:0], 1'b0};
      end
      if (pim >= dsh) begin
        nim = pim - dsh;
        nqi = {pqi[DW-1:0], 1'b1};
      end else begin
        nim = pim;
        nqi = {pqi[DW-1:0], 1'b0};
      end
      // one root digit; the extra divider stage passes the root through
      bsq = SW'(1) << (2 * KK);
      tsq = pr + bsq;
      if (SQ_STEP && (pn >= tsq)) begin
        nn = pn - tsq;
        nr = (pr >> 1) + bsq;
      end else if (SQ_STEP) begin
        nn = pn;
        nr = pr >> 1;
      end else begin
        nn = pn;
        nr = pr;
      end
    end

    assign rdy[j] = !v[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && pv) begin
        ctl[j] <= pc;
        sre[j] <= pse;
        sim[j] <= psi;
        rre[j] <= nre;
        rim[j] <= nim;
        qre[j] <= nqr;
        qim[j] <= nqi;
        den[j] <= pden;
        sn[j]  <= nn;
        sr[j]  <= nr;
      end
    end
  end

  assign out_valid   = v[NS-1];
  assign out_ctrl    = ctl[NS-1];
  assign out_side_re = sre[NS-1];
  assign out_side_im = sim[NS-1];
  assign out_q_re    = qre[NS-1];
  assign out_q_im    = qim[NS-1];
  assign out_root    = sr[NS-1];

endmodule

// File: sv/complex_fixed_point_alu_top.sv
// Top level of the complex fixed-point ALU: front stages, iteration pipe, output stage.
// Registers from input beat to output beat, in order:
//   input register, multiply, sum, prepare, DATA_WIDTH + 1 divide/root stages, output.
// Throughput: one beat per cycle; every stage holds its beat under back-pressure and
//   fills its bubble, so the output register stalling does not block input while
//   earlier stages have room.
// Reset: synchronous, active high, clears all valid bits; data registers are not reset.
module complex_fixed_point_alu_top #(
  parameter int DATA_WIDTH = cfpa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cfpa_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // opcode[2:0], a_re[34:3], a_im[66:35], b_re[98:67], b_im[130:99], zero[135:131]
  input  logic [cfpa_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // res_re[31:0], res_im[63:32], status[65:64], zero[71:66]
  output logic [cfpa_pkg::M_TDATA_W-1:0] m_tdata
);
  import cfpa_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int SW  = 2 * DW;
  localparam int RW  = 2 * DW + FRAC_BITS + 1;   // rounding path
  localparam int RMW = 3 * DW + FRAC_BITS + 2;   // divider remainder
  localparam logic [DW-1:0]        MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]        MINV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

  // ---------------- stage A: input register ----------------
  logic                 va, rdy_b;
  op_t                  op_a;
  logic signed [DW-1:0] ar_a, ai_a, br_a, bi_a;

  assign s_tready = !va || rdy_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (s_tready) begin
      va <= s_tvalid;
    end
  end

  // low DATA_WIDTH bits of each part are the operand
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      op_a <= op_t'(s_tdata[2:0]);
      ar_a <= s_tdata[3 +: DW];
      ai_a <= s_tdata[3 + PART_W +: DW];
      br_a <= s_tdata[3 + 2*PART_W +: DW];
      bi_a <= s_tdata[3 + 3*PART_W +: DW];
    end
  end

  // ---------------- stage B: products and short ops ----------------
  logic                 vb, rdy_c;
  op_t                  op_b;
  logic signed [SW-1:0] p0_b, p1_b, p2_b, p3_b, p4_b, p5_b;
  logic signed [DW:0]   e_re_b, e_im_b;
  logic signed [DW-1:0] sq_x, sq_y;
  logic signed [DW:0]   e_re_n, e_im_n;

  assign rdy_b = !vb || rdy_c;

  // magnitude squares share the divisor-square multipliers
  assign sq_x = (op_a == OP_ABS) ? ar_a : br_a;
  assign sq_y = (op_a == OP_ABS) ? ai_a : bi_a;

  always_comb begin
    case (op_a)
      OP_ADD: begin
        e_re_n = (DW+1)'(ar_a) + (DW+1)'(br_a);
        e_im_n = (DW+1)'(ai_a) + (DW+1)'(bi_a);
      end
      OP_SUB: begin
        e_re_n = (DW+1)'(ar_a) - (DW+1)'(br_a);
        e_im_n = (DW+1)'(ai_a) - (DW+1)'(bi_a);
      end
      OP_CONJ: begin
        e_re_n = (DW+1)'(ar_a);
        e_im_n = -(DW+1)'(ai_a);
      end
      default: begin
        e_re_n = '0;
        e_im_n = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      op_b   <= op_a;
      p0_b   <= ar_a * br_a;
      p1_b   <= ai_a * bi_a;
      p2_b   <= ai_a * br_a;
      p3_b   <= ar_a * bi_a;
      p4_b   <= sq_x * sq_x;
      p5_b   <= sq_y * sq_y;
      e_re_b <= e_re_n;
      e_im_b <= e_im_n;
    end
  end

  // ---------------- stage C: sums of products ----------------
  logic                 vc, rdy_d;
  op_t                  op_c;
  logic signed [SW:0]   sum_re_c, sum_im_c;
  logic [SW-1:0]        sq_c;
  logic signed [DW:0]   e_re_c, e_im_c;

  assign rdy_c = !vc || rdy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb) begin
      op_c <= op_b;
      if (op_b == OP_MUL) begin
        sum_re_c <= (SW+1)'(p0_b) - (SW+1)'(p1_b);
        sum_im_c <= (SW+1)'(p2_b) + (SW+1)'(p3_b);
      end else begin
        sum_re_c <= (SW+1)'(p0_b) + (SW+1)'(p1_b);
        sum_im_c <= (SW+1)'(p2_b) - (SW+1)'(p3_b);
      end
      sq_c   <= $unsigned(p4_b) + $unsigned(p5_b);
      e_re_c <= e_re_b;
      e_im_c <= e_im_b;
    end
  end

  // ---------------- stage D: round/saturate, divider setup ----------------
  logic                 vd, iter_in_ready;
  ctrl_t                ctl_d;
  logic [DW-1:0]        side_re_d, side_im_d;
  logic [RMW-1:0]       num_re_d, num_im_d;
  logic [SW-1:0]        den_d, sq_d;

  logic signed [RW-1:0] rnd_re, rnd_im;
  logic                 fit_rre, fit_rim, fit_ere, fit_eim;
  logic [DW-1:0]        mul_re, mul_im, ex_re, ex_im;
  logic [SW-1:0]        mag_re, mag_im;
  logic [RMW-1:0]       nre_n, nim_n, lim_n;
  ctrl_t                ctl_n;
  logic [DW-1:0]        side_re_n, side_im_n;

  assign rdy_d = !vd || iter_in_ready;

  always_comb begin
    // round to nearest: add half an LSB, then arithmetic shift
    rnd_re  = (RW'(sum_re_c) + HALF) >>> FRAC_BITS;
    rnd_im  = (RW'(sum_im_c) + HALF) >>> FRAC_BITS;
    fit_rre = (rnd_re == RW'($signed(rnd_re[DW-1:0])));
    fit_rim = (rnd_im == RW'($signed(rnd_im[DW-1:0])));
    mul_re  = fit_rre ? rnd_re[DW-1:0] : (rnd_re[RW-1] ? MINV : MAXV);
    mul_im  = fit_rim ? rnd_im[DW-1:0] : (rnd_im[RW-1] ? MINV : MAXV);
    fit_ere = (e_re_c[DW] == e_re_c[DW-1]);
    fit_eim = (e_im_c[DW] == e_im_c[DW-1]);
    ex_re   = fit_ere ? e_re_c[DW-1:0] : (e_re_c[DW] ? MINV : MAXV);
    ex_im   = fit_eim ? e_im_c[DW-1:0] : (e_im_c[DW] ? MINV : MAXV);

    // numerator magnitudes times 2^FRAC_BITS; quotient must fit DATA_WIDTH+1 bits
    mag_re  = SW'(sum_re_c[SW] ? -sum_re_c : sum_re_c);
    mag_im  = SW'(sum_im_c[SW] ? -sum_im_c : sum_im_c);
    nre_n   = RMW'(mag_re) << FRAC_BITS;
    nim_n   = RMW'(mag_im) << FRAC_BITS;
    lim_n   = RMW'(sq_c) << (DW + 1);

    ctl_n.op     = op_c;
    ctl_n.dz     = (sq_c == '0);
    ctl_n.neg_re = sum_re_c[SW];
    ctl_n.neg_im = sum_im_c[SW];
    ctl_n.ovf_re = (nre_n >= lim_n);
    ctl_n.ovf_im = (nim_n >= lim_n);
    if (op_c == OP_MUL) begin
      side_re_n = mul_re;
      side_im_n = mul_im;
      ctl_n.sat = !fit_rre || !fit_rim;
    end else begin
      side_re_n = ex_re;
      side_im_n = ex_im;
      ctl_n.sat = !fit_ere || !fit_eim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (rdy_d) begin
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc) begin
      ctl_d     <= ctl_n;
      side_re_d <= side_re_n;
      side_im_d <= side_im_n;
      num_re_d  <= nre_n;
      num_im_d  <= nim_n;
      den_d     <= sq_c;
      sq_d      <= sq_c;
    end
  end

  // ---------------- divide / root pipe ----------------
  logic          iv, rdy_f;
  ctrl_t         ictl;
  logic [DW-1:0] iside_re, iside_im;
  logic [DW:0]   iq_re, iq_im;
  logic [SW-1:0] iroot;

  cfpa_iter #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_iter (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (vd),
    .in_ready    (iter_in_ready),
    .in_ctrl     (ctl_d),
    .in_side_re  (side_re_d),
    .in_side_im  (side_im_d),
    .in_num_re   (num_re_d),
    .in_num_im   (num_im_d),
    .in_den      (den_d),
    .in_sq       (sq_d),
    .out_valid   (iv),
    .out_ready   (rdy_f),
    .out_ctrl    (ictl),
    .out_side_re (iside_re),
    .out_side_im (iside_im),
    .out_q_re    (iq_re),
    .out_q_im    (iq_im),
    .out_root    (iroot)
  );

  // ---------------- stage F: result select, output register ----------------
  logic                 vf;
  logic [DW-1:0]        res_re_f, res_im_f;
  status_t              status_f;

  logic signed [DW+1:0] dv_re, dv_im;
  logic                 dsat_re, dsat_im, rsat;
  logic [DW-1:0]        dq_re, dq_im, rt;
  logic [DW-1:0]        res_re_n, res_im_n;
  logic                 sat_n;
  status_t              status_n;

  assign rdy_f = !vf || m_tready;

  always_comb begin
    // signed quotient; an oversized quotient is already known to saturate
    dv_re   = ictl.neg_re ? -$signed({1'b0, iq_re}) : $signed({1'b0, iq_re});
    dv_im   = ictl.neg_im ? -$signed({1'b0, iq_im}) : $signed({1'b0, iq_im});
    dsat_re = ictl.ovf_re || (dv_re != (DW+2)'($signed(dv_re[DW-1:0])));
    dsat_im = ictl.ovf_im || (dv_im != (DW+2)'($signed(dv_im[DW-1:0])));
    dq_re   = dsat_re ? (ictl.neg_re ? MINV : MAXV) : dv_re[DW-1:0];
    dq_im   = dsat_im ? (ictl.neg_im ? MINV : MAXV) : dv_im[DW-1:0];
    rsat    = (iroot[SW-1:DW-1] != '0);
    rt      = rsat ? MAXV : iroot[DW-1:0];

    case (ictl.op)
      OP_ADD, OP_SUB, OP_MUL, OP_CONJ: begin
        res_re_n = iside_re;
        res_im_n = iside_im;
        sat_n    = ictl.sat;
      end
      OP_DIV: begin
        res_re_n = ictl.dz ? '0 : dq_re;
        res_im_n = ictl.dz ? '0 : dq_im;
        sat_n    = !ictl.dz && (dsat_re || dsat_im);
      end
      OP_ABS: begin
        res_re_n = rt;
        res_im_n = '0;
        sat_n    = rsat;
      end
      default: begin
        res_re_n = '0;
        res_im_n = '0;
        sat_n    = 1'b0;
      end
    endcase

    priority if ((ictl.op == OP_DIV) && ictl.dz) begin
      status_n = ST_DZ;
    end else if (sat_n) begin
      status_n = ST_SAT;
    end else begin
      status_n = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (rdy_f) begin
      vf <= iv;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && iv) begin
      res_re_f <= res_re_n;
      res_im_f <= res_im_n;
      status_f <= status_n;
    end
  end

  assign m_tvalid = vf;
  // parts sign-extended to the 32-bit port fields
  assign m_tdata  = {{(M_TDATA_W - 2*PART_W - 2){1'b0}}, status_f,
                     PART_W'($signed(res_im_f)), PART_W'($signed(res_re_f))};

endmodule

// File: sv/cfpa_checker.sv
// Port-level checks for the complex fixed-point ALU, bound to the top level.
module cfpa_props (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cfpa_pkg::M_TDATA_W-1:0] m_tdata
);
  import cfpa_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[65:64] == ST_OK) || (m_tdata[65:64] == ST_SAT) ||
                 (m_tdata[65:64] == ST_DZ))
    else $error("undefined status code");

  // divide by zero returns a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[65:64] == ST_DZ) |-> (m_tdata[63:0] == '0))
    else $error("nonzero result with divide-by-zero status");

  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind complex_fixed_point_alu_top cfpa_props u_cfpa_props (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/cfpa_checker.sv
// Watches both stream channels, predicts each ALU result and compares it on the output side.
`timescale 1ns / 1ps
module cfpa_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [cfpa_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [cfpa_pkg::M_TDATA_W-1:0] m_tdata,
  output int                             errors,
  output int                             pending
);
  import cfpa_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    status_t     st;
  } alu_result_t;

  alu_result_t result_q[$];

  // clamp to signed 32 bits, flag saturation
  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic alu_result_t predict_alu(input logic [S_TDATA_W-1:0] d);
    logic signed [127:0] ar, ai, br, bi, den;
    bit                  sat;
    alu_result_t         r;
    ar  = $signed(d[34:3]);
    ai  = $signed(d[66:35]);
    br  = $signed(d[98:67]);
    bi  = $signed(d[130:99]);
    sat = 1'b0;
    r   = '{re: '0, im: '0, st: ST_OK};
    case (d[2:0])
      OP_ADD: begin
        r.re = clamp32(ar + br, sat);
        r.im = clamp32(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp32(ar - br, sat);
        r.im = clamp32(ai - bi, sat);
      end
      OP_MUL: begin
        // round half up, floor after the shift
        r.re = clamp32((ar * br - ai * bi + (128'sd1 <<< (FRAC - 1))) >>> FRAC, sat);
        r.im = clamp32((ai * br + ar * bi + (128'sd1 <<< (FRAC - 1))) >>> FRAC, sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.st = ST_DZ;
        end else begin
          // signed divide truncates toward zero
          r.re = clamp32(((ar * br + ai * bi) <<< FRAC) / den, sat);
          r.im = clamp32(((ai * br - ar * bi) <<< FRAC) / den, sat);
        end
      end
      OP_CONJ: begin
        r.re = ar[31:0];
        r.im = clamp32(-ai, sat);
      end
      OP_ABS: begin
        den  = ar * ar + ai * ai;
        r.re = clamp32($signed({64'd0, floor_sqrt(den[63:0])}), sat);
      end
      default: ;
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) result_q.push_back(predict_alu(s_tdata));
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (m_tdata[31:0] !== want.re) begin
            $display("%0t: res_re expected %h actual %h", $time, want.re, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== want.im) begin
            $display("%0t: res_im expected %h actual %h", $time, want.im, m_tdata[63:32]);
            errors++;
          end
          if (m_tdata[65:64] !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, m_tdata[65:64]);
            errors++;
          end
        end
      end
      pending = result_q.size();
    end
  end

endmodule

// File: dv/complex_fixed_point_alu_top_tb.sv
// Stimulus and verdict for the complex fixed-point ALU; checking lives in cfpa_checker.
`timescale 1ns / 1ps
module complex_fixed_point_alu_top_tb;
  import cfpa_pkg::*;

  localparam int  LATENCY   = DATA_WIDTH_DEF + 6;
  localparam int  LIMIT     = 2_000_000;
  localparam int  N_RANDOM  = 2000;

  // idle modes per phase
  typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH } idle_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;   // opcode, a_re, a_im, b_re, b_im, zero pad
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;   // res_re, res_im, status, zero pad

  int         errors;
  int         pending;
  int         cycles;
  int         hold_off;      // cycles left in a forced receiver stall
  idle_mode_t mode;

  complex_fixed_point_alu_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  cfpa_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("complex_fixed_point_alu_top verification failed");
      $finish;
    end
  end

  // receiver: random stalls by mode, plus forced long stalls
  initial begin
    m_tready = 1'b0;
    hold_off = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready = 1'b0;
        hold_off--;
      end else begin
        case (mode)
          IDLE_SINK: m_tready = ($urandom_range(99) >= 62);
          IDLE_BOTH: m_tready = ($urandom_range(99) >= 9);
          default:   m_tready = 1'b1;
        endcase
      end
    end
  end

  // one beat; valid stays high across back-to-back beats
  task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    int gap_pct;
    gap_pct = (mode == IDLE_SRC) ? 62 : (mode == IDLE_BOTH) ? 9 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {5'd0, bi, br, ai, ar, op};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // full range or small magnitude, so both saturating and exact results show up
  function automatic logic [31:0] rand_part();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      2:       return 32'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      default: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
    endcase
  endfunction

  task automatic random_block(input int n);
    logic [2:0]  op;
    logic [31:0] br;
    logic [31:0] bi;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      br = rand_part();
      bi = rand_part();
      if ($urandom_range(19) == 0) begin
        br = '0;
        bi = '0;
      end
      send_op(op, rand_part(), rand_part(), br, bi);
    end
  endtask

  initial begin
    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    mode     = IDLE_NONE;
    rst      = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every op, special cases
    send_op(OP_ADD,  MAXP, MINN, MAXP, MINN);
    send_op(OP_ADD,  ONE, 32'hffff_0000, ONE, ONE);
    send_op(OP_SUB,  MINN, MAXP, MAXP, MINN);
    send_op(OP_SUB,  32'h0003_8000, 0, ONE, 32'hffff_ffff);
    send_op(OP_MUL,  MAXP, MAXP, MAXP, MAXP);
    send_op(OP_MUL,  MINN, MINN, MINN, MINN);
    send_op(OP_MUL,  32'h0000_8000, 32'h0000_0001, 32'h0000_0001, 32'h0000_8000);
    send_op(OP_MUL,  32'hffff_8000, 0, 32'h0000_0001, 0);
    send_op(OP_MUL,  ONE, ONE, ONE, 32'hffff_0000);
    send_op(OP_DIV,  ONE, ONE, 0, 0);
    send_op(OP_DIV,  MAXP, MINN, 0, 0);
    send_op(OP_DIV,  32'h0003_0000, 32'hfffe_0000, ONE, ONE);
    send_op(OP_DIV,  MAXP, MAXP, 32'h0000_0001, 0);
    send_op(OP_DIV,  MINN, MINN, MINN, MINN);
    send_op(OP_DIV,  32'hffff_ffff, 0, 32'h0003_0000, 0);
    send_op(OP_CONJ, MINN, MINN, 0, 0);
    send_op(OP_CONJ, MAXP, MAXP, MAXP, MAXP);
    send_op(OP_ABS,  MINN, MINN, 0, 0);
    send_op(OP_ABS,  0, 0, MAXP, MINN);
    send_op(OP_ABS,  32'h0003_0000, 32'hfffc_0000, 0, 0);
    send_op(3'd6,    MAXP, MINN, MAXP, MINN);
    send_op(3'd7,    32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // random phases, covering each idle mode, one with a long receiver stall
    mode = IDLE_NONE;
    random_block(N_RANDOM / 5);
    mode = IDLE_SRC;
    random_block(N_RANDOM / 5);
    mode = IDLE_SINK;
    random_block(N_RANDOM / 5);
    mode     = IDLE_NONE;
    hold_off = 300;    // pipe fills and input stalls while the sender keeps offering
    random_block(N_RANDOM / 5);
    mode = IDLE_BOTH;
    random_block(N_RANDOM / 5);

    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);

    if (errors == 0) begin
      $display("complex_fixed_point_alu_top verification clean");
    end else begin
      $display("complex_fixed_point_alu_top verification failed");
    end
    $finish;
  end

endmodule
